// ===== hdl/blphd_pkg.sv =====
// Shared types and constants for the bar level peak-hold/decay block.
// Used by the controller, the datapath and the top level.
package blphd_pkg;

  localparam int MAX_BARS = 32;
  localparam int BAR_W    = $clog2(MAX_BARS);
  localparam int CNT_W    = $clog2(MAX_BARS + 1);

  localparam int LVL_W    = 16;
  localparam int RAW_W    = 32;
  localparam int BCNT_W   = 6;
  localparam int IDX_W    = 5;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BAR_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FALL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_FALL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_HOLD  = 3'd4;

  // item kinds carried on in_tuser
  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [BCNT_W-1:0] BAR_COUNT_RST =
    (16 > MAX_BARS) ? BCNT_W'(MAX_BARS) : BCNT_W'(16);

  typedef struct packed {
    logic [BCNT_W-1:0] bar_count;
    logic [LVL_W-1:0]  level_max;
    logic [LVL_W-1:0]  level_fall;
    logic [LVL_W-1:0]  peak_fall;
    logic              peak_hold_on;
  } cfg_t;

  typedef struct packed {
    logic             load;     // capture the accepted item, clear result
    logic             rd_en;    // read one entry; it is written back next cycle
    logic [BAR_W-1:0] rd_addr;
    logic             emit;     // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic             func;
    logic             active;   // addressed bar is below bar_count
    logic [BAR_W-1:0] idx;
    logic             out_free; // output register can take a result
  } dp_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET,
    ST_TICK,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_t;

endpackage

// ===== hdl/blphd_ctrl.sv =====
// Controller for the bar level peak-hold/decay block: sequences set and
// tick items over the datapath. Depends on blphd_pkg.
module blphd_ctrl import blphd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_accept,
  input  logic    in_func,
  input  cfg_t    cfg,
  input  dp_sts_t sts,
  output logic    in_ready,
  output dp_cmd_t cmd
);

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc = cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.rd_addr = '0;
    cmd.emit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_accept) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = (in_func == FUNC_TICK) ? ST_TICK : ST_SET;
        end
      end
      ST_SET: begin
        // an inactive bar is left alone
        if (sts.active) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = sts.idx;
          state_nxt   = ST_DRAIN;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_TICK: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = cnt_r[BAR_W-1:0];
        cnt_nxt     = cnt_inc;
        if (cnt_inc == CNT_W'(cfg.bar_count)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last write-back happens here
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/blphd_dp.sv =====
// Datapath for the bar level peak-hold/decay block: level/peak store with
// valid bits, read-modify-write update, result capture and output register.
// Depends on blphd_pkg.
module blphd_dp import blphd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  clr,
  input  dp_cmd_t               cmd,
  input  logic                  in_func,
  input  logic [IDX_W-1:0]      in_bar_index,
  input  logic [RAW_W-1:0]      in_new_level,
  input  logic                  out_tready,
  output dp_sts_t               sts,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata,   // level[15:0], peak[31:16]
  output logic [1:0]            out_tuser    // moved[0], ignored[1]
);

  // entry: level in the low half, peak in the high half
  logic [2*LVL_W-1:0] mem_r [MAX_BARS];
  logic [MAX_BARS-1:0] vld_r, vld_nxt;

  logic               func_r;
  logic [IDX_W-1:0]   idx_r;
  logic [RAW_W-1:0]   raw_r;

  logic [2*LVL_W-1:0] rd_data_r;
  logic               rd_vld_r;
  logic               wr_go_r, wr_go_nxt;
  logic [BAR_W-1:0]   wr_addr_r;

  logic [LVL_W-1:0]   res_level_r, res_level_nxt;
  logic [LVL_W-1:0]   res_peak_r, res_peak_nxt;
  logic               moved_r, moved_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [LVL_W-1:0]   out_level_r;
  logic [LVL_W-1:0]   out_peak_r;
  logic               out_moved_r;
  logic               out_ignored_r;

  logic [LVL_W-1:0]   lv_rd, pk_rd;
  logic [LVL_W-1:0]   set_v;
  logic [LVL_W-1:0]   tick_lv, tick_pk;
  logic [LVL_W-1:0]   new_lv, new_pk;
  logic               tick_lv_mv, tick_pk_mv;
  logic               active;

  assign active = ({1'b0, idx_r} < (IDX_W + 1)'(cfg.bar_count)) &&
                  ({1'b0, idx_r} < (IDX_W + 1)'(MAX_BARS));

  // entries never written since the last clear read as zero
  assign lv_rd = rd_vld_r ? rd_data_r[LVL_W-1:0] : '0;
  assign pk_rd = rd_vld_r ? rd_data_r[2*LVL_W-1:LVL_W] : '0;

  // clamp the signed raw value to 0..level_max
  always_comb begin
    if (raw_r[RAW_W-1]) begin
      set_v = '0;
    end else if (raw_r[RAW_W-2:0] > (RAW_W - 1)'(cfg.level_max)) begin
      set_v = cfg.level_max;
    end else begin
      set_v = raw_r[LVL_W-1:0];
    end
  end

  always_comb begin
    tick_lv_mv = (lv_rd != '0);
    if (lv_rd > cfg.level_fall) begin
      tick_lv = lv_rd - cfg.level_fall;
    end else begin
      tick_lv = '0;
    end
    tick_pk_mv = cfg.peak_hold_on && (pk_rd > tick_lv);
    tick_pk    = pk_rd;
    if (tick_pk_mv) begin
      tick_pk = ((pk_rd - tick_lv) > cfg.peak_fall) ? (pk_rd - cfg.peak_fall) : tick_lv;
    end
  end

  always_comb begin
    if (func_r == FUNC_TICK) begin
      new_lv = tick_lv;
      new_pk = tick_pk;
    end else begin
      new_lv = set_v;
      new_pk = (set_v > pk_rd) ? set_v : pk_rd;
    end
  end

  always_comb begin
    wr_go_nxt     = cmd.rd_en;
    res_level_nxt = res_level_r;
    res_peak_nxt  = res_peak_r;
    moved_nxt     = moved_r;
    vld_nxt       = vld_r;
    if (cmd.load) begin
      res_level_nxt = '0;
      res_peak_nxt  = '0;
      moved_nxt     = 1'b0;
    end else if (wr_go_r) begin
      vld_nxt[wr_addr_r] = 1'b1;
      if ({{(IDX_W + 1 - BAR_W){1'b0}}, wr_addr_r} == {1'b0, idx_r}) begin
        res_level_nxt = new_lv;
        res_peak_nxt  = new_pk;
      end
      if (func_r == FUNC_TICK && (tick_lv_mv || tick_pk_mv)) begin
        moved_nxt = 1'b1;
      end
    end
    if (clr) begin
      vld_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      wr_go_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      wr_go_r     <= wr_go_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      idx_r  <= in_bar_index;
      raw_r  <= in_new_level;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem_r[cmd.rd_addr];
      rd_vld_r  <= vld_r[cmd.rd_addr];
      wr_addr_r <= cmd.rd_addr;
    end
    if (wr_go_r) begin
      mem_r[wr_addr_r] <= {new_pk, new_lv};
    end
    res_level_r <= res_level_nxt;
    res_peak_r  <= res_peak_nxt;
    moved_r     <= moved_nxt;
    if (cmd.emit) begin
      out_level_r   <= res_level_r;
      out_peak_r    <= res_peak_r;
      out_moved_r   <= moved_r;
      out_ignored_r <= (func_r == FUNC_SET) && !active;
    end
  end

  assign sts.func     = func_r;
  assign sts.active   = active;
  assign sts.idx      = idx_r[BAR_W-1:0];
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_peak_r, out_level_r};
  assign out_tuser  = {out_ignored_r, out_moved_r};

  // a read never hits the entry being written back in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && wr_go_r) |-> (cmd.rd_addr != wr_addr_r))
    else $error("read and write-back to the same bar in one cycle");

  // a result is only moved into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result emitted over a waiting result");

  // clearing the store drops every valid bit
  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> (vld_r == '0))
    else $error("store not cleared after bar_count write");

endmodule

// ===== hdl/bar_level_peak_hold_decay.sv =====
// Bar meter level and peak-hold store with per-tick decay.
//
// Input channel in_*: one beat per item. in_tuser is the item kind (0 set
// the level of bar in_tdata[4:0] from the signed value in_tdata[36:5],
// 1 decay tick over all active bars). Result channel out_*: exactly one beat
// per item, carrying level and peak of the addressed bar after the item
// (zero for an inactive bar) plus the moved and ignored flags.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while idle;
// the user must keep to this, as the block itself does no check of it. Writing
// bar_count clears all levels and peaks. Items are handled one at a time by a
// controller walking a level/peak store: an active set item reads its entry,
// writes it back and emits the result, an ignored one goes straight to the
// result, and a tick reads and writes back every active entry, one store entry
// visited per cycle. The next item is taken in the cycle after the result is
// loaded into the output register. The result sits in an output register, so
// when out_tready is low the next item is still accepted and processed; it then
// waits until that register frees up, and in_tready stays low meanwhile.
// After reset (rst_n low, synchronous) bar_count is 16, level_max 100,
// level_fall 6, peak_fall 2, peak hold on, and all stores read as zero.
// Depends on blphd_pkg, blphd_ctrl and blphd_dp.
module bar_level_peak_hold_decay import blphd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // bar_index[4:0], new_level[36:5], zeros
  input  logic                  in_tuser,    // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // level[15:0], peak[31:16]
  output logic [1:0]            out_tuser,   // moved[0], ignored[1]
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  logic    clr;
  logic    in_accept;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [BCNT_W-1:0] bcnt_wr;

  assign in_accept = in_tvalid && in_tready;
  assign bcnt_wr   = cfg_wdata[BCNT_W-1:0];
  assign clr       = cfg_wr_en && (cfg_index == REG_BAR_COUNT);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BAR_COUNT: begin
          // limit to 1..MAX_BARS
          if (bcnt_wr == '0) begin
            cfg_nxt.bar_count = BCNT_W'(1);
          end else if ((BCNT_W + 9)'(bcnt_wr) > (BCNT_W + 9)'(MAX_BARS)) begin
            cfg_nxt.bar_count = BCNT_W'(MAX_BARS);
          end else begin
            cfg_nxt.bar_count = bcnt_wr;
          end
        end
        REG_LEVEL_MAX: begin
          cfg_nxt.level_max = (cfg_wdata == '0) ? LVL_W'(1) : cfg_wdata;
        end
        REG_LEVEL_FALL: cfg_nxt.level_fall   = cfg_wdata;
        REG_PEAK_FALL:  cfg_nxt.peak_fall    = cfg_wdata;
        REG_PEAK_HOLD:  cfg_nxt.peak_hold_on = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bar_count    <= BAR_COUNT_RST;
      cfg_r.level_max    <= LVL_W'(100);
      cfg_r.level_fall   <= LVL_W'(6);
      cfg_r.peak_fall    <= LVL_W'(2);
      cfg_r.peak_hold_on <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  blphd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_func   (in_tuser),
    .cfg       (cfg_r),
    .sts       (sts),
    .in_ready  (in_tready),
    .cmd       (cmd)
  );

  blphd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .clr          (clr),
    .cmd          (cmd),
    .in_func      (in_tuser),
    .in_bar_index (in_tdata[IDX_W-1:0]),
    .in_new_level (in_tdata[IDX_W+RAW_W-1:IDX_W]),
    .out_tready   (out_tready),
    .sts          (sts),
    .out_tvalid   (out_tvalid),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for bar_level_peak_hold_decay: directed table, then random phases.
// Keeps its own level/peak store model and checks every result beat against it.
// Depends on blphd_pkg and the bar_level_peak_hold_decay RTL.
module tb_top;
  import blphd_pkg::*;

  localparam int TIMEOUT_T  = 2_000_000;
  localparam int SETTLE_CYC = MAX_BARS + 8;
  localparam int PHASES     = 8;
  localparam int PHASE_BEATS = 163;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] peak;
    logic             moved;
    logic             ignored;
  } readout_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic                 func;
    logic [IDX_W-1:0]     idx;
    logic [RAW_W-1:0]     raw;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_val;
    bit                   typed;
    readout_t             want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DAT_W-1:0]  cfg_wdata;

  // shadow of the block's configuration and stores
  int unsigned      eff_count;
  int unsigned      lvl_max;
  int unsigned      lvl_fall;
  int unsigned      pk_fall;
  bit               hold_on;
  logic [LVL_W-1:0] lvl_mem [MAX_BARS];
  logic [LVL_W-1:0] peak_mem [MAX_BARS];

  readout_t readout_q[$];
  dir_row_t dir_rows[$];
  int       mismatch_cnt = 0;
  int       tx_idle_pct;
  int       rx_stall_pct;

  bar_level_peak_hold_decay dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one item to the shadow stores and return the readout it produces.
  function automatic readout_t meter_step(input logic func, input logic [IDX_W-1:0] idx,
                                          input logic [RAW_W-1:0] raw);
    readout_t    r;
    int unsigned v;
    int unsigned lv;
    int unsigned pk;
    bit          act;
    r = '0;
    act = (idx < eff_count);
    if (func == FUNC_SET) begin
      if (!act) begin
        r.ignored = 1'b1;
      end else begin
        if (raw[RAW_W-1]) v = 0;
        else if (raw > lvl_max) v = lvl_max;
        else v = raw;
        lvl_mem[idx] = LVL_W'(v);
        if (v > peak_mem[idx]) peak_mem[idx] = LVL_W'(v);
      end
    end else begin
      for (int k = 0; k < eff_count; k++) begin
        lv = lvl_mem[k];
        pk = peak_mem[k];
        if (lv > 0) begin
          lv = (lv > lvl_fall) ? lv - lvl_fall : 0;
          r.moved = 1'b1;
        end
        if (hold_on && pk > lv) begin
          pk = (pk - lv > pk_fall) ? pk - pk_fall : lv;
          r.moved = 1'b1;
        end
        lvl_mem[k] = LVL_W'(lv);
        peak_mem[k] = LVL_W'(pk);
      end
    end
    if (act) begin
      r.level = lvl_mem[idx];
      r.peak  = peak_mem[idx];
    end
    return r;
  endfunction

  function automatic dir_row_t item_row(input logic func, input logic [IDX_W-1:0] idx,
                                        input logic [RAW_W-1:0] raw);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.func = func;
    row.idx = idx;
    row.raw = raw;
    row.reg_idx = REG_BAR_COUNT;
    row.reg_val = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t want_row(input logic func, input logic [IDX_W-1:0] idx,
                                        input logic [RAW_W-1:0] raw,
                                        input logic [LVL_W-1:0] lvl, input logic [LVL_W-1:0] pk,
                                        input logic mv, input logic ign);
    dir_row_t row;
    row = item_row(func, idx, raw);
    row.typed = 1'b1;
    row.want = '{level: lvl, peak: pk, moved: mv, ignored: ign};
    return row;
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] ridx,
                                       input logic [CFG_DAT_W-1:0] val);
    dir_row_t row;
    row = item_row(FUNC_SET, '0, '0);
    row.kind = ROW_CFG;
    row.reg_idx = ridx;
    row.reg_val = val;
    return row;
  endfunction

  // Bias toward zero, all ones and small amounts.
  function automatic logic [15:0] spread16();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(1, 12));
      5, 6:    return 16'($urandom_range(13, 400));
      default: return 16'($urandom);
    endcase
  endfunction

  // Entered and left at a falling edge; in_tvalid stays high on return.
  task automatic push_item(input logic func, input logic [IDX_W-1:0] idx,
                           input logic [RAW_W-1:0] raw, input bit typed, input readout_t want);
    int       gap;
    readout_t pred;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = func;
    in_tdata = {3'b000, raw, idx};
    do @(posedge clk); while (!in_tready);
    pred = meter_step(func, idx, raw);
    readout_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Write one register once every readout is back.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] ridx, input logic [CFG_DAT_W-1:0] val);
    int unsigned bc;
    in_tvalid = 1'b0;
    while (readout_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = ridx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (ridx)
      REG_BAR_COUNT: begin
        bc = val[BCNT_W-1:0];
        if (bc < 1) bc = 1;
        if (bc > MAX_BARS) bc = MAX_BARS;
        eff_count = bc;
        lvl_mem = '{default: '0};
        peak_mem = '{default: '0};
      end
      REG_LEVEL_MAX:  lvl_max = (val == 0) ? 1 : val;
      REG_LEVEL_FALL: lvl_fall = val;
      REG_PEAK_FALL:  pk_fall = val;
      REG_PEAK_HOLD:  hold_on = val[0];
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    readout_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (readout_q.size() == 0) begin
        $error("result beat with no readout pending");
        mismatch_cnt++;
      end else begin
        want = readout_q.pop_front();
        if (out_tdata[15:0] !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, out_tdata[15:0]);
          mismatch_cnt++;
        end
        if (out_tdata[31:16] !== want.peak) begin
          $error("peak: expected %0d, got %0d", want.peak, out_tdata[31:16]);
          mismatch_cnt++;
        end
        if (out_tuser[0] !== want.moved) begin
          $error("moved: expected %0d, got %0d", want.moved, out_tuser[0]);
          mismatch_cnt++;
        end
        if (out_tuser[1] !== want.ignored) begin
          $error("ignored: expected %0d, got %0d", want.ignored, out_tuser[1]);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_T);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic             func;
    logic [IDX_W-1:0] idx;
    logic [RAW_W-1:0] raw;
    logic [5:0]       bc;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FUNC_SET;
    cfg_wr_en = 1'b0;
    cfg_index = REG_BAR_COUNT;
    cfg_wdata = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    eff_count = BAR_COUNT_RST;
    lvl_max = 100;
    lvl_fall = 6;
    pk_fall = 2;
    hold_on = 1'b1;
    lvl_mem = '{default: '0};
    peak_mem = '{default: '0};

    // reset defaults first, then the special settings one by one
    dir_rows.push_back(want_row(FUNC_TICK, 5'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0));
    dir_rows.push_back(want_row(FUNC_SET, 5'd0, 32'd50, 16'd50, 16'd50, 1'b0, 1'b0));
    dir_rows.push_back(want_row(FUNC_SET, 5'd31, 32'd7, 16'd0, 16'd0, 1'b0, 1'b1));
    dir_rows.push_back(want_row(FUNC_SET, 5'd1, 32'h7FFF_FFFF, 16'd100, 16'd100, 1'b0, 1'b0));
    dir_rows.push_back(want_row(FUNC_SET, 5'd2, 32'h8000_0000, 16'd0, 16'd0, 1'b0, 1'b0));
    dir_rows.push_back(want_row(FUNC_SET, 5'd3, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0, 1'b0));
    dir_rows.push_back(want_row(FUNC_TICK, 5'd0, 32'hFFFF_FFFF, 16'd44, 16'd48, 1'b1, 1'b0));
    dir_rows.push_back(item_row(FUNC_TICK, 5'd1, 32'd0));
    dir_rows.push_back(want_row(FUNC_SET, 5'd15, 32'd100, 16'd100, 16'd100, 1'b0, 1'b0));
    dir_rows.push_back(want_row(FUNC_SET, 5'd16, 32'd5, 16'd0, 16'd0, 1'b0, 1'b1));
    dir_rows.push_back(want_row(FUNC_SET, 5'd4, 32'd1, 16'd1, 16'd1, 1'b0, 1'b0));
    dir_rows.push_back(want_row(FUNC_TICK, 5'd4, 32'd0, 16'd0, 16'd0, 1'b1, 1'b0));
    dir_rows.push_back(reg_row(REG_LEVEL_FALL, 16'd0));
    dir_rows.push_back(reg_row(REG_PEAK_FALL, 16'd0));
    dir_rows.push_back(item_row(FUNC_TICK, 5'd0, 32'd0));
    dir_rows.push_back(reg_row(REG_PEAK_HOLD, 16'd0));
    dir_rows.push_back(reg_row(REG_LEVEL_FALL, 16'd6));
    dir_rows.push_back(want_row(FUNC_SET, 5'd5, 32'd200, 16'd100, 16'd100, 1'b0, 1'b0));
    dir_rows.push_back(want_row(FUNC_TICK, 5'd5, 32'd0, 16'd94, 16'd100, 1'b1, 1'b0));
    dir_rows.push_back(reg_row(REG_BAR_COUNT, 16'd0));
    dir_rows.push_back(want_row(FUNC_TICK, 5'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0));
    dir_rows.push_back(want_row(FUNC_SET, 5'd1, 32'd9, 16'd0, 16'd0, 1'b0, 1'b1));
    dir_rows.push_back(want_row(FUNC_SET, 5'd0, 32'd9, 16'd9, 16'd9, 1'b0, 1'b0));
    dir_rows.push_back(reg_row(REG_LEVEL_MAX, 16'd0));
    dir_rows.push_back(want_row(FUNC_SET, 5'd0, 32'd65535, 16'd1, 16'd9, 1'b0, 1'b0));
    dir_rows.push_back(reg_row(REG_BAR_COUNT, 16'd63));
    dir_rows.push_back(want_row(FUNC_SET, 5'd31, 32'd65535, 16'd1, 16'd1, 1'b0, 1'b0));
    dir_rows.push_back(reg_row(REG_LEVEL_MAX, 16'hFFFF));
    dir_rows.push_back(want_row(FUNC_SET, 5'd31, 32'd70000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    dir_rows.push_back(item_row(FUNC_SET, 5'd30, 32'h0000_FFFF));
    dir_rows.push_back(reg_row(REG_LEVEL_FALL, 16'hFFFF));
    dir_rows.push_back(reg_row(REG_PEAK_FALL, 16'hFFFF));
    dir_rows.push_back(reg_row(REG_PEAK_HOLD, 16'd1));
    dir_rows.push_back(want_row(FUNC_TICK, 5'd31, 32'd0, 16'd0, 16'd0, 1'b1, 1'b0));
    dir_rows.push_back(item_row(FUNC_SET, 5'd17, 32'd3));

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else
        push_item(dir_rows[i].func, dir_rows[i].idx, dir_rows[i].raw,
                  dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
        default: begin tx_idle_pct = 6; rx_stall_pct = 6; end
      endcase
      case ($urandom_range(5))
        0:       bc = 6'd0;
        1:       bc = 6'd63;
        2:       bc = 6'd1;
        3:       bc = 6'd32;
        default: bc = 6'($urandom_range(1, 63));
      endcase
      // upper data bits carry noise that the register must drop
      cfg_write(REG_BAR_COUNT, {10'($urandom), bc});
      cfg_write(REG_LEVEL_MAX, spread16());
      cfg_write(REG_LEVEL_FALL, spread16());
      cfg_write(REG_PEAK_FALL, spread16());
      cfg_write(REG_PEAK_HOLD, 16'($urandom));
      repeat (PHASE_BEATS) begin
        func = ($urandom_range(99) < 25) ? FUNC_TICK : FUNC_SET;
        if ($urandom_range(99) < 85) idx = IDX_W'($urandom_range(eff_count - 1));
        else idx = IDX_W'($urandom_range(31));
        case ($urandom_range(9))
          0, 1, 2, 3: raw = $urandom_range(lvl_max + lvl_max / 4 + 1);
          4, 5:       raw = $urandom;
          6:          raw = {1'b1, 31'($urandom)};
          7:          raw = $urandom_range(20);
          default:    raw = lvl_max - 1 + $urandom_range(2);
        endcase
        push_item(func, idx, raw, 1'b0, '0);
      end
    end

    in_tvalid = 1'b0;
    while (readout_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    if (mismatch_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/blphd_pkg.sv
hdl/blphd_ctrl.sv
hdl/blphd_dp.sv
hdl/bar_level_peak_hold_decay.sv
tb/sv/tb_top.sv
